>>> sv/tx_ring_buffer_packetizer_macros.svh
// assertion macros shared by the transmit ring buffer packetizer
// no dependencies; included by files that carry concurrent assertions
`ifndef TX_RING_BUFFER_PACKETIZER_MACROS_SVH
`define TX_RING_BUFFER_PACKETIZER_MACROS_SVH

// same-cycle implication, held off while aresetn is low
`define TXRB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("txrb check failed");

// next-cycle implication, held off while aresetn is low
`define TXRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("txrb check failed");

`endif

>>> sv/txrb_pkg.sv
// shared types and constants of the transmit ring buffer packetizer
// no dependencies
`timescale 1ns / 1ps

package txrb_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);
    localparam int CHUNK_W      = 5;
    localparam int BYTE_W       = 8;
    localparam int FREE_W       = 8;
    localparam int ACT_W        = 2;
    localparam int KIND_W       = 2;
    localparam int APB_AW       = 4;
    localparam int APB_DW       = 32;
    localparam int REG_IDX_W    = 2;

    // action codes on the input channel
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DONE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_LINK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STOPPED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_MAX_CHUNK = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAY_CMD   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TAG       = 2'd2;

    localparam logic [CHUNK_W-1:0] MAX_CHUNK_RST = 5'd31;
    localparam logic [BYTE_W-1:0]  PAY_CMD_RST   = 8'd160;
    localparam logic [BYTE_W-1:0]  TAG_RST       = 8'd80;

    typedef struct packed {
        logic [CHUNK_W-1:0] max_chunk;
        logic [BYTE_W-1:0]  payload_command;
        logic [BYTE_W-1:0]  stream_tag;
    } txrb_cfg_t;

    // commands from controller to datapath
    typedef struct packed {
        logic do_write;
        logic do_flush;
        logic do_stop;
        logic do_cmd;
        logic do_tag;
        logic do_data;
    } txrb_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic buf_empty;
        logic rem_one;
        logic out_free;
    } txrb_stat_t;

endpackage

>>> sv/txrb_regs.sv
// configuration register bank with apb-style access
// depends on txrb_pkg
`timescale 1ns / 1ps

module txrb_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [txrb_pkg::APB_AW-1:0] paddr,
    input  logic [txrb_pkg::APB_DW-1:0] pwdata,
    output logic [txrb_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output txrb_pkg::txrb_cfg_t         cfg
);
    import txrb_pkg::*;

    txrb_cfg_t            cfg_reg;
    txrb_cfg_t            cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_MAX_CHUNK: cfg_next.max_chunk       = pwdata[CHUNK_W-1:0];
                REG_PAY_CMD:   cfg_next.payload_command = pwdata[BYTE_W-1:0];
                REG_TAG:       cfg_next.stream_tag      = pwdata[BYTE_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MAX_CHUNK: prdata = APB_DW'(cfg_reg.max_chunk);
            REG_PAY_CMD:   prdata = APB_DW'(cfg_reg.payload_command);
            REG_TAG:       prdata = APB_DW'(cfg_reg.stream_tag);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_chunk       <= MAX_CHUNK_RST;
            cfg_reg.payload_command <= PAY_CMD_RST;
            cfg_reg.stream_tag      <= TAG_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/txrb_ctrl.sv
// controller: sequences one input beat at a time and the burst phases
// depends on txrb_pkg
`timescale 1ns / 1ps

module txrb_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [txrb_pkg::ACT_W-1:0] action,
    input  txrb_pkg::txrb_stat_t       stat,
    output txrb_pkg::txrb_cmd_t        cmd
);
    import txrb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TAG  = 2'd1;
    localparam logic [1:0] ST_DATA = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (action)
                        ACT_WRITE: cmd.do_write = 1'b1;
                        ACT_FLUSH: cmd.do_flush = 1'b1;
                        ACT_DONE: begin
                            if (stat.buf_empty) begin
                                cmd.do_stop = 1'b1;
                            end else begin
                                cmd.do_cmd = 1'b1;
                                state_next = ST_TAG;
                            end
                        end
                        default: cmd = '0;
                    endcase
                end
            end
            ST_TAG: begin
                if (stat.out_free) begin
                    cmd.do_tag = 1'b1;
                    state_next = ST_DATA;
                end
            end
            ST_DATA: begin
                if (stat.out_free) begin
                    cmd.do_data = 1'b1;
                    if (stat.rem_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/txrb_dp.sv
// datapath: byte store, pointers, burst count and the output register
// depends on txrb_pkg
`timescale 1ns / 1ps

module txrb_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  txrb_pkg::txrb_cfg_t         cfg,
    input  txrb_pkg::txrb_cmd_t         cmd,
    output txrb_pkg::txrb_stat_t        stat,
    input  logic [txrb_pkg::BYTE_W-1:0] data_byte,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [txrb_pkg::KIND_W-1:0] m_kind,
    output logic [txrb_pkg::BYTE_W-1:0] m_link_byte,
    output logic                        m_last,
    output logic [txrb_pkg::FREE_W-1:0] m_free_space,
    output logic                        m_overflow
);
    import txrb_pkg::*;

    localparam int CMP_W = (PTR_W > CHUNK_W) ? PTR_W : CHUNK_W;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    logic [BYTE_W-1:0]  mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0]  rdata_reg;

    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [CHUNK_W-1:0] rem_reg, rem_next;
    logic [FREE_W-1:0]  bfree_reg, bfree_next;

    logic               valid_reg, valid_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic               last_reg, last_next;
    logic [FREE_W-1:0]  free_reg, free_next;
    logic               ovf_reg, ovf_next;

    logic [PTR_W-1:0]   fill;
    logic [PTR_W-1:0]   space;
    logic [CHUNK_W-1:0] lim;
    logic [CHUNK_W-1:0] cnt;
    logic               full;
    logic               load;

    always_comb begin
        if (wp_reg >= rp_reg) begin
            fill = wp_reg - rp_reg;
        end else begin
            fill = PTR_W'({1'b0, wp_reg} + (PTR_W+1)'(BUFFER_DEPTH) - {1'b0, rp_reg});
        end
    end

    assign space = PTR_W'(BUFFER_DEPTH - 1) - fill;
    assign full  = (space == '0);
    assign lim   = (cfg.max_chunk == '0) ? CHUNK_W'(1) : cfg.max_chunk;
    assign cnt   = (CMP_W'(fill) > CMP_W'(lim)) ? lim : CHUNK_W'(fill);

    assign load  = cmd.do_write || cmd.do_flush || cmd.do_stop ||
                   cmd.do_cmd || cmd.do_tag || cmd.do_data;

    always_comb begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        rem_next   = rem_reg;
        bfree_next = bfree_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        free_next  = free_reg;
        ovf_next   = ovf_reg;

        if (cmd.do_write) begin
            kind_next = KIND_STATUS;
            byte_next = '0;
            last_next = 1'b1;
            ovf_next  = full;
            if (full) begin
                free_next = '0;
            end else begin
                wp_next   = ptr_inc(wp_reg);
                free_next = FREE_W'(space - 1'b1);
            end
        end
        if (cmd.do_flush) begin
            wp_next   = '0;
            rp_next   = '0;
            kind_next = KIND_STATUS;
            byte_next = '0;
            last_next = 1'b1;
            ovf_next  = 1'b0;
            free_next = FREE_W'(BUFFER_DEPTH - 1);
        end
        if (cmd.do_stop) begin
            kind_next = KIND_STOPPED;
            byte_next = '0;
            last_next = 1'b1;
            ovf_next  = 1'b0;
            free_next = FREE_W'(space);
        end
        if (cmd.do_cmd) begin
            rem_next   = cnt;
            bfree_next = FREE_W'(space) + FREE_W'(cnt);
            kind_next  = KIND_LINK;
            byte_next  = cfg.payload_command;
            last_next  = 1'b0;
            ovf_next   = 1'b0;
            free_next  = FREE_W'(space) + FREE_W'(cnt);
        end
        if (cmd.do_tag) begin
            kind_next = KIND_LINK;
            byte_next = cfg.stream_tag;
            last_next = 1'b0;
            ovf_next  = 1'b0;
            free_next = bfree_reg;
        end
        if (cmd.do_data) begin
            rp_next   = ptr_inc(rp_reg);
            rem_next  = rem_reg - 1'b1;
            kind_next = KIND_LINK;
            byte_next = rdata_reg;
            last_next = (rem_reg == CHUNK_W'(1));
            ovf_next  = 1'b0;
            free_next = bfree_reg;
        end
    end

    // output register empties on a taken beat, refills on any load
    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // store: one write port, one registered read port that tracks the next read pointer
    always_ff @(posedge aclk) begin
        if (cmd.do_write && !full) begin
            mem[wp_reg] <= data_byte;
        end
        rdata_reg <= mem[rp_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            rem_reg   <= rem_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bfree_reg <= bfree_next;
        kind_reg  <= kind_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        free_reg  <= free_next;
        ovf_reg   <= ovf_next;
    end

    assign stat.buf_empty = (fill == '0);
    assign stat.rem_one   = (rem_reg == CHUNK_W'(1));
    assign stat.out_free  = !valid_reg || m_tready;

    assign m_tvalid     = valid_reg;
    assign m_kind       = kind_reg;
    assign m_link_byte  = byte_reg;
    assign m_last       = last_reg;
    assign m_free_space = free_reg;
    assign m_overflow   = ovf_reg;

endmodule

>>> sv/tx_ring_buffer_packetizer.sv
// top level of the transmit ring buffer packetizer
// depends on txrb_pkg, txrb_regs, txrb_ctrl, txrb_dp and the macros header
//
//   channel   direction  handshake            payload
//   s_        in         s_tvalid/s_tready    tuser action, tdata data_byte
//   m_        out        m_tvalid/m_tready    tuser kind, tlast last,
//                                             tdata link_byte/free_space/overflow
//   apb       in         psel/penable/pready  max_chunk, payload_command, stream_tag
//
// after a write, flush or empty-buffer done beat the result sits in the output register;
// the next input beat can be taken in the same cycle it leaves; a done beat with data
// yields 2 + n result beats (n = min(fill, max_chunk), max_chunk 0 counting as 1),
// one per cycle while m_tready stays high; the single byte-store read port sets that pace
// aresetn (synchronous, active low) empties the buffer and loads register defaults;
// the byte store itself is not cleared
// a stalled m_ side holds the current result and blocks new input beats
`timescale 1ns / 1ps

`include "tx_ring_buffer_packetizer_macros.svh"

module tx_ring_buffer_packetizer (
    input  logic                        aclk,
    input  logic                        aresetn,

    // input channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] data_byte
    input  logic [1:0]                  s_tuser,   // [1:0] action

    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // [7:0] link_byte, [15:8] free_space,
                                                   // [16] overflow, [23:17] zero
    output logic [1:0]                  m_tuser,   // [1:0] kind
    output logic                        m_tlast,

    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [txrb_pkg::APB_AW-1:0] paddr,
    input  logic [txrb_pkg::APB_DW-1:0] pwdata,
    output logic [txrb_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import txrb_pkg::*;

    txrb_cfg_t          cfg;
    txrb_cmd_t          cmd;
    txrb_stat_t         stat;

    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  link_byte;
    logic [FREE_W-1:0]  free_space;
    logic               overflow;

    // register bank
    txrb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: idle, tag beat, data beats
    txrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (s_tuser[ACT_W-1:0]),
        .stat     (stat),
        .cmd      (cmd)
    );

    // buffer, pointers and output register
    txrb_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cmd          (cmd),
        .stat         (stat),
        .data_byte    (s_tdata[BYTE_W-1:0]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_kind       (kind),
        .m_link_byte  (link_byte),
        .m_last       (m_tlast),
        .m_free_space (free_space),
        .m_overflow   (overflow)
    );

    // pack the result beat, lowest field first
    assign m_tdata = {7'd0, overflow, free_space, link_byte};
    assign m_tuser = kind;

    // at most one datapath command per cycle
    `TXRB_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd))
    // no input beat is taken while a burst is still being sent
    `TXRB_ASSERT_NOW(a_no_accept_in_burst, cmd.do_tag || cmd.do_data, !s_tready)
    // a burst opens with a link byte that is not marked last
    `TXRB_ASSERT_NEXT(a_burst_head, cmd.do_cmd, m_tvalid && !m_tlast && m_tuser == KIND_LINK)
    // overflow is only ever flagged on a status beat
    `TXRB_ASSERT_NOW(a_ovf_status, m_tvalid && m_tdata[16], m_tuser == KIND_STATUS)

endmodule
